FILE: sv/particle_set_statistics_top_assert.svh
// assertion macros for the particle set statistics block
`ifndef PARTICLE_SET_STATISTICS_TOP_ASSERT_SVH
`define PARTICLE_SET_STATISTICS_TOP_ASSERT_SVH
`ifndef SYNTH
`define PSS_ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define PSS_ASSERT_NXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`else
`define PSS_ASSERT_IMP(label, clk, rst_n, a, c)
`define PSS_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

FILE: sv/pss_pkg.sv
// ----------------------------------------------------------------------------
// pss_pkg
// shared types and constants of the particle set statistics block
// ----------------------------------------------------------------------------
`default_nettype none
package pss_pkg;
	localparam int MAX_PARTICLES_DEF = 1024;
	localparam int COORD_W = 32;
	localparam int BOX_W = 34;
	localparam int ENERGY_W = 64;
	localparam int OVL_W = 33;
	localparam int CNT_W = 11;

	// one particle handed from the front to the back
	typedef struct packed {
		logic signed [COORD_W-1:0] px;
		logic signed [COORD_W-1:0] py;
		logic signed [COORD_W-1:0] pz;
		logic [COORD_W-1:0] r;
		logic [COORD_W-1:0] vx;
		logic [COORD_W-1:0] vy;
		logic [COORD_W-1:0] vz;
		logic [COORD_W-1:0] m;
		logic last;
	} item_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_RD,
		ST_RDJ,
		ST_DIFF,
		ST_SQRT,
		ST_CMP,
		ST_OUT
	} state_t;
endpackage
`default_nettype wire

FILE: sv/pss_ram.sv
// ----------------------------------------------------------------------------
// pss_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none
module pss_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 1024
) (
	input  wire logic clk,
	input  wire logic we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

FILE: sv/pss_front.sv
// ----------------------------------------------------------------------------
// pss_front
// two entry input queue toward the back part
// ----------------------------------------------------------------------------
`default_nettype none
module pss_front (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	output logic full,
	input  wire pss_pkg::item_t in_item,
	output logic q_valid,
	input  wire logic q_take,
	output pss_pkg::item_t q_item
);
	pss_pkg::item_t buf_q [2];
	logic rd_q, wr_q;
	logic [1:0] cnt_q;
	logic do_push;

	assign full = (cnt_q == 2'd2);
	assign do_push = push && !full;
	assign q_valid = (cnt_q != 2'd0);
	assign q_item = buf_q[rd_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (do_push) buf_q[wr_q] <= in_item;
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wr_q <= !wr_q;
			if (q_take) rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, q_take};
		end
	end
endmodule
`default_nettype wire

FILE: sv/pss_back.sv
// ----------------------------------------------------------------------------
// pss_back
// energy and box accumulation, particle store, pairwise overlap pass
// ----------------------------------------------------------------------------
`default_nettype none
`include "particle_set_statistics_top_assert.svh"
module pss_back #(
	parameter int MAX_PARTICLES = pss_pkg::MAX_PARTICLES_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic q_valid,
	output logic q_take,
	input  wire pss_pkg::item_t q_item,
	output logic empty,
	input  wire logic pop,
	output logic [63:0] kinetic_energy,
	output logic signed [33:0] box_min_x,
	output logic signed [33:0] box_min_y,
	output logic signed [33:0] box_min_z,
	output logic signed [33:0] box_max_x,
	output logic signed [33:0] box_max_y,
	output logic signed [33:0] box_max_z,
	output logic [10:0] collided_count,
	output logic [32:0] max_overlap
);
	localparam int AW = $clog2(MAX_PARTICLES);
	localparam int NW = $clog2(MAX_PARTICLES + 1);

	pss_pkg::state_t st_q, st_d;
	logic [NW-1:0] cnt_q;
	logic [NW-1:0] i_q, j_q;
	logic [63:0] esum_q;
	logic signed [33:0] lo_q [3];
	logic signed [33:0] hi_q [3];
	logic [10:0] ocnt_q;
	logic [32:0] peak_q;
	logic hit_q;
	logic out_v_q;

	// energy pipeline: squares, then products
	logic e_v_s1, e_v_s2, e_last_s1, e_last_s2, e_last_s3, e_v_s3;
	logic [63:0] sq_s1 [3];
	logic [31:0] m_s1;
	logic [65:0] ssum_s2;
	logic [31:0] m_s2;
	logic [97:0] plo_s3, phi_s3;
	logic [63:0] term_s4;
	logic e_v_s4, e_last_s4;

	// store and pair datapath
	logic ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [127:0] ram_wdata, ram_rdata;
	logic [127:0] a_q;
	logic [32:0] dabs_q [3];
	logic [65:0] dsq_q;
	logic [1:0] sqs_q;
	logic [67:0] op_q, res_q, one_q;
	logic [5:0] sit_q;
	logic [32:0] rsum_q;
	logic [67:0] sq_t;

	logic take;
	logic [2:0] drain;
	logic en_busy;

	// accept into the back while loading, no result is pending and no last particle is in the energy pipeline
	assign en_busy = e_v_s1 || e_v_s2 || e_v_s3 || e_v_s4;
	assign take = (st_q == pss_pkg::ST_LOAD) && q_valid && !out_v_q && !e_last_s1 &&
		!e_last_s2 && !e_last_s3 && !e_last_s4;
	assign q_take = take;
	assign drain = 3'd0;

	// energy stages 1 to 3: velocity squares, their sum, partial products with the mass
	always_ff @(posedge clk) begin
		sq_s1[0] <= 64'($signed(q_item.vx) * $signed(q_item.vx));
		sq_s1[1] <= 64'($signed(q_item.vy) * $signed(q_item.vy));
		sq_s1[2] <= 64'($signed(q_item.vz) * $signed(q_item.vz));
		m_s1 <= q_item.m;
		ssum_s2 <= {2'b0, sq_s1[0]} + {2'b0, sq_s1[1]} + {2'b0, sq_s1[2]};
		m_s2 <= m_s1;
		plo_s3 <= 98'({ssum_s2[31:0]} * m_s2);
		phi_s3 <= 98'({ssum_s2[65:32]} * m_s2);
	end

	// energy stage 4: combine, shift and saturate
	logic [129:0] prod;
	assign prod = {32'b0, plo_s3} + {phi_s3, 32'b0};
	always_ff @(posedge clk) begin
		term_s4 <= (|prod[129:81]) ? 64'hFFFF_FFFF_FFFF_FFFF : prod[80:17];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{e_v_s1, e_v_s2, e_v_s3, e_v_s4} <= '0;
			{e_last_s1, e_last_s2, e_last_s3, e_last_s4} <= '0;
		end else begin
			e_v_s1 <= take;
			e_v_s2 <= e_v_s1;
			e_v_s3 <= e_v_s2;
			e_v_s4 <= e_v_s3;
			e_last_s1 <= take && q_item.last;
			e_last_s2 <= e_last_s1;
			e_last_s3 <= e_last_s2;
			e_last_s4 <= e_last_s3;
		end
	end

	// bounds candidates
	logic signed [33:0] cl [3], ch [3];
	always_comb begin
		cl[0] = 34'(q_item.px) - $signed({2'b0, q_item.r});
		cl[1] = 34'(q_item.py) - $signed({2'b0, q_item.r});
		cl[2] = 34'(q_item.pz) - $signed({2'b0, q_item.r});
		ch[0] = 34'(q_item.px) + $signed({2'b0, q_item.r});
		ch[1] = 34'(q_item.py) + $signed({2'b0, q_item.r});
		ch[2] = 34'(q_item.pz) + $signed({2'b0, q_item.r});
	end

	// store write
	assign ram_we = take && (cnt_q < NW'(MAX_PARTICLES));
	assign ram_waddr = cnt_q[AW-1:0];
	assign ram_wdata = {q_item.px, q_item.py, q_item.pz, q_item.r};
	assign ram_raddr = (st_q == pss_pkg::ST_RD) ? i_q[AW-1:0] : j_q[AW-1:0];

	pss_ram #(.WIDTH(128), .DEPTH(MAX_PARTICLES)) u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	// pair differences
	logic signed [32:0] dd [3];
	always_comb begin
		dd[0] = 33'($signed(a_q[127:96])) - 33'($signed(ram_rdata[127:96]));
		dd[1] = 33'($signed(a_q[95:64])) - 33'($signed(ram_rdata[95:64]));
		dd[2] = 33'($signed(a_q[63:32])) - 33'($signed(ram_rdata[63:32]));
	end
	assign sq_t = res_q + one_q;

	// sequencer
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			pss_pkg::ST_LOAD: if (e_last_s4) st_d = pss_pkg::ST_RD;
			pss_pkg::ST_RD: st_d = (i_q + NW'(1) < cnt_q) ? pss_pkg::ST_RDJ : pss_pkg::ST_OUT;
			pss_pkg::ST_RDJ: st_d = pss_pkg::ST_DIFF;
			pss_pkg::ST_DIFF: if (sqs_q == 2'd3) st_d = pss_pkg::ST_SQRT;
			pss_pkg::ST_SQRT: if (sit_q == 6'd34) st_d = pss_pkg::ST_CMP;
			pss_pkg::ST_CMP: st_d = (j_q + NW'(1) < cnt_q) ? pss_pkg::ST_RDJ : pss_pkg::ST_RD;
			pss_pkg::ST_OUT: st_d = pss_pkg::ST_LOAD;
			default: st_d = pss_pkg::ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= pss_pkg::ST_LOAD;
		else st_q <= st_d;
	end

	// pass datapath
	always_ff @(posedge clk) begin
		unique case (st_q)
			pss_pkg::ST_RD: j_q <= i_q + NW'(1);
			pss_pkg::ST_RDJ: begin
				if (j_q == i_q + NW'(1)) a_q <= ram_rdata;
				sqs_q <= 2'd0;
			end
			pss_pkg::ST_DIFF: begin
				sqs_q <= sqs_q + 2'd1;
				if (sqs_q == 2'd0) begin
					a_q <= a_q;
					dabs_q[0] <= dd[0][32] ? 33'(-dd[0]) : 33'(dd[0]);
					dabs_q[1] <= dd[1][32] ? 33'(-dd[1]) : 33'(dd[1]);
					dabs_q[2] <= dd[2][32] ? 33'(-dd[2]) : 33'(dd[2]);
					rsum_q <= {1'b0, a_q[31:0]} + {1'b0, ram_rdata[31:0]};
					dsq_q <= '0;
				end else begin
					dsq_q <= dsq_q + 66'(dabs_q[sqs_q - 2'd1] * dabs_q[sqs_q - 2'd1]);
				end
				op_q <= {2'b0, dsq_q};
				res_q <= '0;
				one_q <= {2'b01, 66'b0};
				sit_q <= '0;
			end
			pss_pkg::ST_SQRT: begin
				sit_q <= sit_q + 6'd1;
				if (sit_q == 6'd0) op_q <= {2'b0, dsq_q};
				else if (op_q >= sq_t) begin
					op_q <= op_q - sq_t;
					res_q <= (res_q >> 1) + one_q;
				end else res_q <= res_q >> 1;
				if (sit_q != 6'd0) one_q <= one_q >> 2;
			end
			pss_pkg::ST_CMP: j_q <= j_q + NW'(1);
			default: ;
		endcase
	end

	// set statistics and result register
	logic [64:0] esum_n;
	assign esum_n = {1'b0, esum_q} + {1'b0, term_s4};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0; esum_q <= '0; ocnt_q <= '0; peak_q <= '0;
			hit_q <= 1'b0; out_v_q <= 1'b0; i_q <= '0;
			for (int k = 0; k < 3; k++) begin lo_q[k] <= '0; hi_q[k] <= '0; end
		end else begin
			if (take) begin
				for (int k = 0; k < 3; k++) begin
					if (cnt_q == '0 || cl[k] < lo_q[k]) lo_q[k] <= cl[k];
					if (cnt_q == '0 || ch[k] > hi_q[k]) hi_q[k] <= ch[k];
				end
				if (cnt_q < NW'(MAX_PARTICLES)) cnt_q <= cnt_q + NW'(1);
				else if (cnt_q == '0) cnt_q <= cnt_q;
			end
			if (e_v_s4) esum_q <= esum_n[64] ? '1 : esum_n[63:0];
			if (st_q == pss_pkg::ST_CMP) begin
				if ({1'b0, rsum_q} > {1'b0, res_q[32:0]} && res_q[67:33] == '0 ||
					{2'b0, rsum_q} > res_q[34:0] && res_q[67:35] == '0) begin
					hit_q <= 1'b1;
					if (rsum_q - res_q[32:0] > peak_q) peak_q <= rsum_q - res_q[32:0];
				end
				if (!(j_q + NW'(1) < cnt_q)) begin
					i_q <= i_q + NW'(1);
				end
			end
			if (st_q == pss_pkg::ST_RD && hit_q) begin
				ocnt_q <= ocnt_q + 11'd1;
				hit_q <= 1'b0;
			end
			if (st_q == pss_pkg::ST_OUT) begin
				out_v_q <= 1'b1;
				kinetic_energy <= esum_q;
				box_min_x <= lo_q[0]; box_min_y <= lo_q[1]; box_min_z <= lo_q[2];
				box_max_x <= hi_q[0]; box_max_y <= hi_q[1]; box_max_z <= hi_q[2];
				collided_count <= ocnt_q;
				max_overlap <= peak_q;
				cnt_q <= '0; esum_q <= '0; ocnt_q <= '0; peak_q <= '0;
				hit_q <= 1'b0; i_q <= '0;
			end else if (pop && out_v_q) out_v_q <= 1'b0;
		end
	end

	assign empty = !out_v_q;

	`PSS_ASSERT_IMP(a_no_take_in_pass, clk, arst_n, st_q != pss_pkg::ST_LOAD, !q_take)
	`PSS_ASSERT_NXT(a_out_sets_valid, clk, arst_n, st_q == pss_pkg::ST_OUT, out_v_q)
	`PSS_ASSERT_IMP(a_no_take_pending, clk, arst_n, out_v_q, !q_take)
	`PSS_ASSERT_IMP(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= NW'(MAX_PARTICLES))
	`PSS_ASSERT_IMP(a_no_drain, clk, arst_n, en_busy, drain == 3'd0)
endmodule
`default_nettype wire

FILE: sv/particle_set_statistics_top.sv
// ----------------------------------------------------------------------------
// particle_set_statistics_top
// particle set energy, bounding box and pairwise overlap statistics
// ----------------------------------------------------------------------------
// usage: particles enter on a queue style port (push/full), one transfer per
// cycle while full is low. each particle adds its kinetic energy through a
// four stage multiplier pipeline, extends the box and is written to the
// store ram. the particle marked last_particle starts the pairwise pass
// over the store: each pair goes through a ram read, three squarings on
// one shared multiplier, a 34 step bit-serial square root and a compare,
// and the pass adds one ram read per row. one result then sits
// on the result ports while empty is low, taken by pop; the next set is not
// taken in until the result transfer completes, while a two entry queue
// keeps absorbing input. reset clears all set statistics and control; the
// store needs no clearing since only entries of the current set are read.
// ----------------------------------------------------------------------------
`default_nettype none
module particle_set_statistics_top #(
	parameter int MAX_PARTICLES = pss_pkg::MAX_PARTICLES_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	output logic full,
	input  wire logic signed [31:0] pos_x,
	input  wire logic signed [31:0] pos_y,
	input  wire logic signed [31:0] pos_z,
	input  wire logic signed [31:0] vel_x,
	input  wire logic signed [31:0] vel_y,
	input  wire logic signed [31:0] vel_z,
	input  wire logic [31:0] radius,
	input  wire logic [31:0] mass,
	input  wire logic last_particle,
	output logic empty,
	input  wire logic pop,
	output logic [63:0] kinetic_energy,
	output logic signed [33:0] box_min_x,
	output logic signed [33:0] box_min_y,
	output logic signed [33:0] box_min_z,
	output logic signed [33:0] box_max_x,
	output logic signed [33:0] box_max_y,
	output logic signed [33:0] box_max_z,
	output logic [10:0] collided_count,
	output logic [32:0] max_overlap
);
	pss_pkg::item_t in_item, q_item;
	logic q_valid, q_take;

	assign in_item = '{px: pos_x, py: pos_y, pz: pos_z, r: radius,
		vx: vel_x, vy: vel_y, vz: vel_z, m: mass, last: last_particle};

	pss_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_item(in_item),
		.q_valid(q_valid), .q_take(q_take), .q_item(q_item)
	);

	pss_back #(.MAX_PARTICLES(MAX_PARTICLES)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_take(q_take), .q_item(q_item),
		.empty(empty), .pop(pop), .kinetic_energy(kinetic_energy),
		.box_min_x(box_min_x), .box_min_y(box_min_y), .box_min_z(box_min_z),
		.box_max_x(box_max_x), .box_max_y(box_max_y), .box_max_z(box_max_z),
		.collided_count(collided_count), .max_overlap(max_overlap)
	);
endmodule
`default_nettype wire
